// ===== rtl/core/cbd_pkg.sv =====
// ----------------------------------------------------------------------------
// cbd_pkg
// Shared types and codes for the collision brake decision block.
// ----------------------------------------------------------------------------
package cbd_pkg;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_MON   = 3'd1;
    localparam logic [2:0] MODE_PRE   = 3'd2;
    localparam logic [2:0] MODE_BRAKE = 3'd3;
    localparam logic [2:0] MODE_FAULT = 3'd4;

    localparam logic [2:0] RSN_SENSOR = 3'd0;
    localparam logic [2:0] RSN_HOLD   = 3'd1;
    localparam logic [2:0] RSN_NOOBJ  = 3'd2;
    localparam logic [2:0] RSN_CLEAR  = 3'd3;
    localparam logic [2:0] RSN_MON    = 3'd4;
    localparam logic [2:0] RSN_BRAKE  = 3'd5;
    localparam logic [2:0] RSN_WARN   = 3'd6;

    localparam logic [2:0] KIND_CAR  = 3'd0;
    localparam logic [2:0] KIND_PED  = 3'd1;
    localparam logic [2:0] KIND_OBST = 3'd2;
    localparam logic [2:0] KIND_NONE = 3'd3;

    // register indexes, byte address is 4 * index
    localparam logic [2:0] REG_CAR   = 3'd0;
    localparam logic [2:0] REG_PED   = 3'd1;
    localparam logic [2:0] REG_OBST  = 3'd2;
    localparam logic [2:0] REG_WARN  = 3'd3;
    localparam logic [2:0] REG_FLOOR = 3'd4;
    localparam logic [2:0] REG_CEIL  = 3'd5;
    localparam logic [2:0] REG_HYST  = 3'd6;

    typedef enum logic [1:0] {
        OP_RESET,
        OP_FAULT,
        OP_DIV,
        OP_FIX
    } t_op;

    typedef struct packed {
        logic               cmd;
        logic [2:0]         object_kind;
        logic signed [31:0] ego_speed;
        logic signed [31:0] distance;
        logic signed [31:0] closing_speed;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         mode;
        logic               brake_now;
        logic [16:0]        duty;
        logic               buzzer;
        logic               warning;
        logic signed [31:0] time_to_collision;
        logic signed [31:0] needed_decel;
        logic [2:0]         reason_code;
    } t_out_item;

    // classified frame handed from front to back
    typedef struct packed {
        t_op                op;
        logic [2:0]         kind;
        logic signed [31:0] ego;
        logic signed [31:0] obj_dist;
        logic signed [31:0] rel;
        logic signed [31:0] ttc_fix;
    } t_entry;

    typedef struct packed {
        logic [30:0] car_thr;
        logic [30:0] ped_thr;
        logic [30:0] obst_thr;
        logic [30:0] warn_factor;
        logic [16:0] duty_floor;
        logic [16:0] duty_ceiling;
        logic [7:0]  hyst;
    } t_cfg;

endpackage

// ===== rtl/core/cbd_front.sv =====
// ----------------------------------------------------------------------------
// cbd_front
// Frame validation and classification, feeding a two-entry queue.
// ----------------------------------------------------------------------------
module cbd_front import cbd_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_in_item i_in_data,
    output logic     o_in_stall,
    output logic     o_ent_valid,
    output t_entry   o_ent,
    input  logic     i_pop
);
    localparam logic signed [31:0] Q_ONE   = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] NEG_ONE = -Q_ONE;
    localparam logic signed [31:0] REL_LIM = 32'(100 * (1 << FRAC_BITS));

    t_entry     r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_count;
    t_entry     ent;
    logic       push;

    always_comb begin
        ent.kind     = i_in_data.object_kind;
        ent.ego      = i_in_data.ego_speed;
        ent.obj_dist = i_in_data.distance;
        ent.rel      = i_in_data.closing_speed;
        ent.ttc_fix  = Q_MAX;
        ent.op       = OP_FIX;
        if (i_in_data.cmd) begin
            ent.op = OP_RESET;
        end else if (i_in_data.object_kind > KIND_NONE || i_in_data.ego_speed < 0 ||
                     i_in_data.distance < NEG_ONE || i_in_data.closing_speed > REL_LIM ||
                     i_in_data.closing_speed < -REL_LIM) begin
            ent.op = OP_FAULT;
        end else if (i_in_data.distance < 0) begin
            ent.ttc_fix = Q_MIN;
        end else if (i_in_data.distance == 0) begin
            ent.ttc_fix = '0;
        end else if (i_in_data.closing_speed == 0) begin
            ent.ttc_fix = Q_MAX;
        end else if (i_in_data.closing_speed < 0) begin
            ent.ttc_fix = Q_MIN;
        end else begin
            ent.op = OP_DIV;
        end
    end

    assign o_in_stall  = r_count[1];
    assign push        = i_in_valid && !r_count[1];
    assign o_ent_valid = r_count != 2'd0;
    assign o_ent       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= ent;
        end
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_count <= r_count + 2'(push) - 2'(i_pop);
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3) else $error("queue count out of range");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != 2'd0) else $error("pop from empty queue");
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !i_pop) |=> r_count == $past(r_count) + 2'd1)
        else $error("queue count missed a push");

endmodule

// ===== rtl/core/cbd_div.sv =====
// ----------------------------------------------------------------------------
// cbd_div
// Radix-2 restoring divider: (num << FRAC_BITS) / den, saturated to 31 bits.
// ----------------------------------------------------------------------------
module cbd_div import cbd_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [30:0] i_num,
    input  logic [30:0] i_den,
    output logic        o_done,
    output logic [30:0] o_quo
);
    localparam int DW = 31 + FRAC_BITS;
    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] r_quo;
    logic [30:0]   r_rem;
    logic [30:0]   r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy, r_done;
    logic [31:0]   sh;
    logic          ge;

    assign sh = {r_rem, r_quo[DW-1]};
    assign ge = sh >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= {i_num, FRAC_BITS'(0)};
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? 31'(sh - {1'b0, r_den}) : sh[30:0];
            r_quo <= {r_quo[DW-2:0], ge};
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CW'(DW);
        end else begin
            r_done <= r_busy && r_cnt == CW'(1);
            if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) r_busy <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = (|r_quo[DW-1:31]) ? '1 : r_quo[30:0];

endmodule

// ===== rtl/core/cbd_back.sv =====
// ----------------------------------------------------------------------------
// cbd_back
// Time to collision, warning and duty evaluation, and the mode controller.
// ----------------------------------------------------------------------------
module cbd_back import cbd_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cfg      i_cfg,
    input  logic      i_ent_valid,
    input  t_entry    i_ent,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);
    localparam int UW = FRAC_BITS + 1;
    localparam logic [UW-1:0] ONE_U = UW'(1) << FRAC_BITS;

    typedef enum logic [3:0] {
        S_WAIT, S_TTC, S_WMUL, S_EVAL, S_URG, S_DUTY, S_PWM, S_DEC_START, S_DEC, S_FIN
    } t_state;

    t_state              r_state;
    t_op                 r_op;
    logic [2:0]          r_kind;
    logic signed [31:0]  r_ego, r_ttc, r_decel;
    logic [30:0]         r_thr, r_wthr, r_q;
    logic                r_live, r_warn, r_brake;
    logic signed [UW+18:0] r_prod;
    logic [16:0]         r_duty;
    logic [2:0]          r_ctrl;
    logic [7:0]          r_trun, r_crun;
    logic                r_out_valid;
    t_out_item           r_out;
    logic                r_div_start;
    logic [30:0]         r_div_num, r_div_den;
    logic                div_done;
    logic [30:0]         div_quo;

    logic [30:0]         thr_sel;
    logic [61:0]         wprod;
    logic [61:0]         wsh;
    logic [UW-1:0]       urg;
    logic signed [17:0]  span;
    logic signed [UW+18:0] psh;
    logic signed [18:0]  pwm, lo_s, hi_s;
    logic                out_free;
    t_out_item           n_out;
    logic [2:0]          n_ctrl;
    logic [7:0]          n_trun, n_crun;
    logic                threat;

    cbd_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(r_div_start),
        .i_num  (r_div_num),
        .i_den  (r_div_den),
        .o_done (div_done),
        .o_quo  (div_quo)
    );

    always_comb begin
        case (i_ent.kind)
            KIND_CAR:  thr_sel = i_cfg.car_thr;
            KIND_PED:  thr_sel = i_cfg.ped_thr;
            KIND_OBST: thr_sel = i_cfg.obst_thr;
            default:   thr_sel = Q_MAX[30:0];
        endcase
        wprod = {31'd0, r_thr} * {31'd0, i_cfg.warn_factor};
        wsh   = wprod >> FRAC_BITS;
        urg   = ONE_U - r_q[UW-1:0];
        span  = $signed({1'b0, i_cfg.duty_ceiling}) - $signed({1'b0, i_cfg.duty_floor});
        psh   = r_prod >>> FRAC_BITS;
        lo_s  = $signed({2'b0, i_cfg.duty_floor});
        hi_s  = $signed({2'b0, i_cfg.duty_ceiling});
        pwm   = lo_s + psh[18:0];
    end

    assign o_pop    = r_state == S_WAIT && i_ent_valid;
    assign out_free = !r_out_valid || !i_out_stall;

    // controller update and result for the finished frame
    always_comb begin
        n_ctrl = r_ctrl;
        n_trun = r_trun;
        n_crun = r_crun;
        threat = r_warn || r_brake;
        n_out  = '0;
        n_out.time_to_collision = r_ttc;
        n_out.needed_decel      = r_decel;
        n_out.mode              = MODE_IDLE;
        n_out.reason_code       = RSN_CLEAR;
        case (r_op)
            OP_RESET: begin
                n_ctrl = MODE_IDLE;
                n_trun = '0;
                n_crun = '0;
                n_out.time_to_collision = Q_MAX;
                n_out.needed_decel      = '0;
            end
            OP_FAULT: begin
                n_ctrl = MODE_FAULT;
                n_out.mode              = MODE_FAULT;
                n_out.reason_code       = RSN_SENSOR;
                n_out.time_to_collision = Q_MAX;
                n_out.needed_decel      = '0;
            end
            default: begin
                if (r_ctrl == MODE_FAULT) begin
                    n_out.mode        = MODE_FAULT;
                    n_out.reason_code = RSN_HOLD;
                end else if (r_kind == KIND_NONE) begin
                    n_ctrl = MODE_IDLE;
                    n_trun = '0;
                    n_crun = '0;
                    n_out.reason_code = RSN_NOOBJ;
                end else begin
                    if (threat) begin
                        if (r_trun != 8'hFF) n_trun = r_trun + 8'd1;
                        n_crun = '0;
                    end else begin
                        if (r_crun != 8'hFF) n_crun = r_crun + 8'd1;
                        n_trun = '0;
                    end
                    if (!threat && n_crun >= i_cfg.hyst) begin
                        n_ctrl = MODE_IDLE;
                        n_out.reason_code = RSN_CLEAR;
                    end else if (threat && n_trun < i_cfg.hyst) begin
                        if (r_ctrl == MODE_IDLE) n_ctrl = MODE_MON;
                        n_out.warning     = r_warn;
                        n_out.reason_code = RSN_MON;
                    end else if (threat) begin
                        n_out.buzzer = 1'b1;
                        if (r_brake) begin
                            n_ctrl = MODE_BRAKE;
                            n_out.brake_now   = 1'b1;
                            n_out.duty        = r_duty;
                            n_out.reason_code = RSN_BRAKE;
                        end else begin
                            n_ctrl = MODE_PRE;
                            n_out.warning     = 1'b1;
                            n_out.reason_code = RSN_WARN;
                        end
                    end else begin
                        n_out.reason_code = RSN_MON;
                    end
                    n_out.mode = n_ctrl;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_WAIT;
            r_ctrl      <= MODE_IDLE;
            r_trun      <= '0;
            r_crun      <= '0;
            r_out_valid <= 1'b0;
            r_div_start <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && r_state != S_FIN) r_out_valid <= 1'b0;
            case (r_state)
                S_WAIT: begin
                    if (i_ent_valid) begin
                        r_op    <= i_ent.op;
                        r_kind  <= i_ent.kind;
                        r_ego   <= i_ent.ego;
                        r_thr   <= thr_sel;
                        r_ttc   <= i_ent.ttc_fix;
                        r_warn  <= 1'b0;
                        r_brake <= 1'b0;
                        r_duty  <= '0;
                        r_decel <= '0;
                        case (i_ent.op)
                            OP_DIV: begin
                                r_div_start <= 1'b1;
                                r_div_num   <= i_ent.obj_dist[30:0];
                                r_div_den   <= i_ent.rel[30:0];
                                r_state     <= S_TTC;
                            end
                            OP_FIX:  r_state <= S_WMUL;
                            default: r_state <= S_FIN;
                        endcase
                    end
                end
                S_TTC: begin
                    r_div_start <= 1'b0;
                    if (div_done) begin
                        r_ttc   <= $signed({1'b0, div_quo});
                        r_state <= S_WMUL;
                    end
                end
                S_WMUL: begin
                    r_wthr  <= (|wsh[61:31]) ? Q_MAX[30:0] : wsh[30:0];
                    r_live  <= r_ego > 0 && r_ttc > 0 && r_ttc != Q_MAX;
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    r_warn  <= r_live && r_ttc[30:0] < r_wthr;
                    r_brake <= r_live && r_ttc[30:0] < r_thr;
                    if (r_live && r_ttc[30:0] < r_thr) begin
                        r_div_start <= 1'b1;
                        r_div_num   <= r_ttc[30:0];
                        r_div_den   <= r_thr;
                        r_state     <= S_URG;
                    end else begin
                        r_state <= S_DEC_START;
                    end
                end
                S_URG: begin
                    r_div_start <= 1'b0;
                    if (div_done) begin
                        r_q     <= div_quo;
                        r_state <= S_DUTY;
                    end
                end
                S_DUTY: begin
                    r_prod  <= $signed({1'b0, urg}) * span;
                    r_state <= S_PWM;
                end
                S_PWM: begin
                    if (pwm < lo_s) r_duty <= i_cfg.duty_floor;
                    else if (pwm > hi_s) r_duty <= i_cfg.duty_ceiling;
                    else r_duty <= pwm[16:0];
                    r_state <= S_DEC_START;
                end
                S_DEC_START: begin
                    if (r_ttc <= 0) begin
                        r_decel <= Q_MAX;
                        r_state <= S_FIN;
                    end else begin
                        r_div_start <= 1'b1;
                        r_div_num   <= r_ego[30:0];
                        r_div_den   <= r_ttc[30:0];
                        r_state     <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_div_start <= 1'b0;
                    if (div_done) begin
                        r_decel <= $signed({1'b0, div_quo});
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_out       <= n_out;
                        r_out_valid <= 1'b1;
                        r_ctrl      <= n_ctrl;
                        r_trun      <= n_trun;
                        r_crun      <= n_crun;
                        r_state     <= S_WAIT;
                    end
                end
                default: r_state <= S_WAIT;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_duty_brake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.duty != '0) |-> r_out.brake_now)
        else $error("duty without brake command");
    a_brake_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.brake_now) |-> r_out.mode == MODE_BRAKE)
        else $error("brake command outside braking mode");
    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctrl == MODE_FAULT && !(r_state == S_FIN && r_op == OP_RESET))
        |=> r_ctrl == MODE_FAULT) else $error("fault left without reset command");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state != S_WAIT) else $error("entry popped but not started");

endmodule

// ===== rtl/core/collision_brake_decision.sv =====
// ----------------------------------------------------------------------------
// collision_brake_decision
// Sensor frame validation, time to collision and brake/warning control.
// ----------------------------------------------------------------------------
// Reset commands and invalid frames skip the divider; a frame with a
//   computed time to collision (Q16.16 by default) makes up to three passes
//   through the shared radix-2 divider, with urgency and needed deceleration.
// A two-entry queue takes further frames while a frame is evaluated.
// Reset: synchronous active low; registers to defaults, mode idle, counters 0.
module collision_brake_decision import cbd_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in_item    i_in_data,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_out_item   o_out_data,
    input  logic        i_out_stall,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    t_cfg   r_cfg;
    logic   ent_valid, pop;
    t_entry ent;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.car_thr      <= 31'd131072;
            r_cfg.ped_thr      <= 31'd196608;
            r_cfg.obst_thr     <= 31'd98304;
            r_cfg.warn_factor  <= 31'd85197;
            r_cfg.duty_floor   <= 17'd19661;
            r_cfg.duty_ceiling <= 17'd65536;
            r_cfg.hyst         <= 8'd3;
        end else if (psel && penable && pwrite) begin
            case (paddr[4:2])
                REG_CAR:   r_cfg.car_thr      <= pwdata[30:0];
                REG_PED:   r_cfg.ped_thr      <= pwdata[30:0];
                REG_OBST:  r_cfg.obst_thr     <= pwdata[30:0];
                REG_WARN:  r_cfg.warn_factor  <= pwdata[30:0];
                REG_FLOOR: r_cfg.duty_floor   <= pwdata[16:0];
                REG_CEIL:  r_cfg.duty_ceiling <= pwdata[16:0];
                REG_HYST:  r_cfg.hyst         <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            REG_CAR:   prdata = {1'b0, r_cfg.car_thr};
            REG_PED:   prdata = {1'b0, r_cfg.ped_thr};
            REG_OBST:  prdata = {1'b0, r_cfg.obst_thr};
            REG_WARN:  prdata = {1'b0, r_cfg.warn_factor};
            REG_FLOOR: prdata = {15'd0, r_cfg.duty_floor};
            REG_CEIL:  prdata = {15'd0, r_cfg.duty_ceiling};
            REG_HYST:  prdata = {24'd0, r_cfg.hyst};
            default:   prdata = '0;
        endcase
    end

    cbd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .o_ent_valid(ent_valid),
        .o_ent      (ent),
        .i_pop      (pop)
    );

    cbd_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_ent_valid(ent_valid),
        .i_ent      (ent),
        .o_pop      (pop),
        .o_out_valid(o_out_valid),
        .o_out_data (o_out_data),
        .i_out_stall(i_out_stall)
    );

endmodule

// ===== dv/collision_brake_decision_chk.sv =====
// ----------------------------------------------------------------------------
// collision_brake_decision_chk
// Watches the frame and decision channels and the register port, predicts
// each decision from its own copy of the controller state and compares it.
// ----------------------------------------------------------------------------
module collision_brake_decision_chk import cbd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in_item    i_in_data,
    input  logic        i_in_stall,
    input  logic        i_out_valid,
    input  t_out_item   i_out_data,
    input  logic        i_out_stall,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = 16;
    localparam longint ONE = 64'sd1 <<< FB;
    localparam longint QMX = 64'sd2147483647;
    localparam longint QMN = -64'sd2147483648;

    t_cfg      cfg;
    logic [2:0] st_mode;
    int        threat_cnt, clear_cnt;
    t_out_item decision_q[$];
    int        fails;

    assign o_fail_count = fails;
    assign o_pending    = decision_q.size();

    function automatic longint sat(longint v);
        if (v > QMX) return QMX;
        if (v < QMN) return QMN;
        return v;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        longint p;
        p = a * b;
        if (p >= 0) return sat(p >>> FB);
        return sat(-((-p + ONE - 1) >>> FB));
    endfunction

    function automatic longint fx_div(longint a, longint b);
        if (b == 0) return a > 0 ? QMX : QMN;
        return sat((a * ONE) / b);
    endfunction

    function automatic t_out_item decide(t_in_item f);
        t_out_item r;
        longint ego, obj_dist, rel, thr, ttc, pwm, lo, hi, urg;
        logic warn, brake, threat;
        ego      = f.ego_speed;
        obj_dist = f.distance;
        rel      = f.closing_speed;
        r = '0;
        r.mode = MODE_IDLE;
        r.reason_code = RSN_CLEAR;
        r.time_to_collision = Q_MAX;
        if (f.cmd) begin
            st_mode = MODE_IDLE;
            threat_cnt = 0;
            clear_cnt = 0;
            return r;
        end
        if (f.object_kind > KIND_NONE || ego < 0 || obj_dist < -ONE
                || rel > 100 * ONE || rel < -100 * ONE) begin
            st_mode = MODE_FAULT;
            r.mode = MODE_FAULT;
            r.reason_code = RSN_SENSOR;
            return r;
        end
        case (f.object_kind)
            KIND_CAR:  thr = cfg.car_thr;
            KIND_PED:  thr = cfg.ped_thr;
            KIND_OBST: thr = cfg.obst_thr;
            default:   thr = QMX;
        endcase
        if (obj_dist < 0) ttc = QMN;
        else if (obj_dist == 0) ttc = 0;
        else if (rel == 0) ttc = QMX;
        else if (rel < 0) ttc = QMN;
        else ttc = fx_div(obj_dist, rel);
        warn = 0;
        brake = 0;
        pwm = 0;
        if (ego > 0 && ttc > 0 && ttc != QMX && ttc != QMN) begin
            warn = ttc < fx_mul(thr, longint'(cfg.warn_factor));
            if (ttc < thr) begin
                lo = cfg.duty_floor;
                hi = cfg.duty_ceiling;
                urg = ONE - fx_div(ttc, thr);
                if (urg < 0) urg = 0;
                if (urg > ONE) urg = ONE;
                pwm = lo + fx_mul(urg, hi - lo);
                if (pwm < lo) pwm = lo;
                else if (pwm > hi) pwm = hi;
                brake = 1;
            end
        end
        r.time_to_collision = ttc[31:0];
        r.needed_decel = (ttc <= 0) ? Q_MAX : 32'(fx_div(ego, ttc));
        if (st_mode == MODE_FAULT) begin
            r.mode = MODE_FAULT;
            r.reason_code = RSN_HOLD;
        end else if (f.object_kind == KIND_NONE) begin
            st_mode = MODE_IDLE;
            threat_cnt = 0;
            clear_cnt = 0;
            r.reason_code = RSN_NOOBJ;
        end else begin
            threat = brake | warn;
            if (threat) begin
                if (threat_cnt < 255) threat_cnt++;
                clear_cnt = 0;
            end else begin
                if (clear_cnt < 255) clear_cnt++;
                threat_cnt = 0;
            end
            if (!threat && clear_cnt >= cfg.hyst) begin
                st_mode = MODE_IDLE;
                r.reason_code = RSN_CLEAR;
            end else if (threat && threat_cnt < cfg.hyst) begin
                if (st_mode == MODE_IDLE) st_mode = MODE_MON;
                r.warning = warn;
                r.reason_code = RSN_MON;
            end else if (threat) begin
                r.buzzer = 1;
                if (brake) begin
                    st_mode = MODE_BRAKE;
                    r.brake_now = 1;
                    r.duty = pwm[16:0];
                    r.reason_code = RSN_BRAKE;
                end else begin
                    st_mode = MODE_PRE;
                    r.warning = 1;
                    r.reason_code = RSN_WARN;
                end
            end else begin
                r.reason_code = RSN_MON;
            end
            r.mode = st_mode;
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item exp_d;
        if (!i_rst_n) begin
            cfg.car_thr      <= 31'd131072;
            cfg.ped_thr      <= 31'd196608;
            cfg.obst_thr     <= 31'd98304;
            cfg.warn_factor  <= 31'd85197;
            cfg.duty_floor   <= 17'd19661;
            cfg.duty_ceiling <= 17'd65536;
            cfg.hyst         <= 8'd3;
            st_mode = MODE_IDLE;
            threat_cnt = 0;
            clear_cnt = 0;
            fails = 0;
            decision_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_CAR:   cfg.car_thr      <= i_pwdata[30:0];
                    REG_PED:   cfg.ped_thr      <= i_pwdata[30:0];
                    REG_OBST:  cfg.obst_thr     <= i_pwdata[30:0];
                    REG_WARN:  cfg.warn_factor  <= i_pwdata[30:0];
                    REG_FLOOR: cfg.duty_floor   <= i_pwdata[16:0];
                    REG_CEIL:  cfg.duty_ceiling <= i_pwdata[16:0];
                    REG_HYST:  cfg.hyst         <= i_pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) decision_q.push_back(decide(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (decision_q.size() == 0) begin
                    fails++;
                    if (fails <= 10) $display("ERROR: unexpected decision %p", i_out_data);
                end else begin
                    exp_d = decision_q.pop_front();
                    if (exp_d !== i_out_data) begin
                        fails++;
                        if (fails <= 10)
                            $display("ERROR: decision mismatch\n  exp %p\n  got %p",
                                     exp_d, i_out_data);
                    end
                end
            end
        end
    end
endmodule

// ===== dv/collision_brake_decision_tb.sv =====
// ----------------------------------------------------------------------------
// collision_brake_decision_tb
// Drives sensor frames, reset commands and register writes with random
// gaps and output stalls; the checker scores every decision.
// ----------------------------------------------------------------------------
module collision_brake_decision_tb import cbd_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WDOG_LIMIT = 20000;
    localparam int ONE_Q = 65536;

    logic        clk, rst_n;
    logic        in_valid, in_stall, out_valid, out_stall;
    t_in_item    in_data;
    t_out_item   out_data;
    logic        psel, penable, pwrite, pready;
    logic [4:0]  paddr;
    logic [31:0] pwdata, prdata;
    int          fail_count, pending, idle_cycles;
    logic        timed_out;

    collision_brake_decision u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_data(in_data), .o_in_stall(in_stall),
        .o_out_valid(out_valid), .o_out_data(out_data), .i_out_stall(out_stall),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    collision_brake_decision_chk u_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_data(in_data), .i_in_stall(in_stall),
        .i_out_valid(out_valid), .i_out_data(out_data), .i_out_stall(out_stall),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_pready(pready),
        .i_paddr(paddr), .i_pwdata(pwdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver stalls, with calm stretches
    always @(posedge clk) begin
        if (!rst_n) out_stall <= 0;
        else if (($urandom & 255) < 8) out_stall <= 0;
        else out_stall <= ($urandom_range(0, 99) < 25);
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end
    assign timed_out = idle_cycles >= WDOG_LIMIT;

    // valid stays up between back-to-back transactions; drain() drops it
    task automatic send(t_in_item f);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= f;
        in_valid <= 1;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic reg_write(logic [2:0] idx, logic [31:0] v);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (pending != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic t_in_item frame(logic [2:0] k, int ego, int dist_v, int rel);
        t_in_item f;
        f.cmd = 0; f.object_kind = k;
        f.ego_speed = ego; f.distance = dist_v; f.closing_speed = rel;
        return f;
    endfunction

    // mostly plausible approach frames, some raw noise
    function automatic t_in_item rand_frame();
        t_in_item f;
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) begin
            f = '0;
            f.cmd = 1;
            f.object_kind = 3'($urandom);
            f.ego_speed = $urandom; f.distance = $urandom; f.closing_speed = $urandom;
        end else if (r < 12) begin
            f = frame(3'($urandom), $urandom, $urandom, $urandom);
        end else begin
            f = frame($urandom_range(0, 9) == 0 ? KIND_NONE : 3'($urandom_range(0, 2)),
                      $urandom_range(0, 40 * ONE_Q),
                      $urandom_range(0, 9) == 0 ? -$urandom_range(0, ONE_Q)
                                                : $urandom_range(0, 120 * ONE_Q),
                      $urandom_range(0, 9) == 0 ? -$urandom_range(0, 100 * ONE_Q)
                                                : $urandom_range(0, 100 * ONE_Q));
        end
        return f;
    endfunction

    task automatic random_cfg();
        reg_write(REG_CAR, $urandom_range(0, 6 * ONE_Q));
        reg_write(REG_PED, $urandom_range(0, 6 * ONE_Q));
        reg_write(REG_OBST, $urandom_range(0, 6 * ONE_Q));
        reg_write(REG_WARN, $urandom_range(0, 3 * ONE_Q));
        reg_write(REG_FLOOR, $urandom_range(0, ONE_Q));
        reg_write(REG_CEIL, $urandom_range(0, ONE_Q));
        reg_write(REG_HYST, $urandom_range(0, 9) == 0 ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 5));
    endtask

    initial begin
        t_in_item rc;
        rst_n = 0; in_valid = 0; in_data = '0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        rc = '0; rc.cmd = 1;
        // directed: each class closing in, hysteresis into braking
        repeat (4) send(frame(KIND_CAR, 20 * ONE_Q, 10 * ONE_Q, 10 * ONE_Q));
        send(frame(KIND_PED, 10 * ONE_Q, 30 * ONE_Q, 12 * ONE_Q));
        send(frame(KIND_OBST, 5 * ONE_Q, ONE_Q, 50 * ONE_Q));
        send(frame(KIND_CAR, 20 * ONE_Q, 0, 10 * ONE_Q));
        send(frame(KIND_CAR, 20 * ONE_Q, 10 * ONE_Q, 0));
        send(frame(KIND_CAR, 20 * ONE_Q, 10 * ONE_Q, -5 * ONE_Q));
        send(frame(KIND_CAR, 20 * ONE_Q, -ONE_Q, 5 * ONE_Q));
        send(frame(KIND_CAR, 0, 2 * ONE_Q, 5 * ONE_Q));
        send(frame(KIND_CAR, 32'h7fff_ffff, 32'h7fff_ffff, 100 * ONE_Q));
        send(frame(KIND_NONE, ONE_Q, ONE_Q, ONE_Q));
        send(frame(3'd7, ONE_Q, ONE_Q, ONE_Q));
        send(frame(KIND_CAR, 20 * ONE_Q, 10 * ONE_Q, 10 * ONE_Q));
        send(frame(KIND_CAR, -1, ONE_Q, ONE_Q));
        send(frame(KIND_CAR, ONE_Q, -ONE_Q - 1, ONE_Q));
        send(frame(KIND_CAR, ONE_Q, ONE_Q, 100 * ONE_Q + 1));
        send(frame(KIND_CAR, ONE_Q, ONE_Q, 32'h8000_0000));
        send(rc);
        send(frame(KIND_CAR, ONE_Q, ONE_Q, -100 * ONE_Q));
        drain();

        // extremes: zero hysteresis, floor above ceiling, huge thresholds
        reg_write(REG_CAR, 32'h7fff_ffff); reg_write(REG_PED, 0);
        reg_write(REG_OBST, 32'h7fff_ffff);
        reg_write(REG_WARN, 32'h7fff_ffff); reg_write(REG_FLOOR, ONE_Q);
        reg_write(REG_CEIL, 0);
        reg_write(REG_HYST, 0);
        repeat (3) send(frame(KIND_CAR, 20 * ONE_Q, 10 * ONE_Q, 10 * ONE_Q));
        send(frame(KIND_PED, 20 * ONE_Q, 10 * ONE_Q, 10 * ONE_Q));
        send(rc);
        drain();
        reg_write(REG_HYST, 255);
        repeat (300) send(frame(KIND_OBST, 30 * ONE_Q, ONE_Q, 90 * ONE_Q));
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            random_cfg();
            repeat (150) send(rand_frame());
            drain();
        end
        if (fail_count == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end

    initial begin
        @(posedge timed_out);
        $display("Test completed with failures");
        $finish;
    end
endmodule
